@@ src/pdec_pkg.sv @@
// shared types, constants and hex helpers for the percent-escape decoder
package pdec_pkg;

    // escape introducer
    localparam logic [7:0] PCT_CHAR = 8'h25;

    // default depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;

    // most bytes one input item can produce
    localparam int MAX_EMIT = 3;

    // escape phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } pdec_phase_t;

    // bytes produced by one input item, byte 0 goes out first
    typedef struct packed {
        logic [MAX_EMIT-1:0][7:0] bytes;
        logic [1:0]               count;
        logic                     last;
    } pdec_entry_t;

    // true for 0-9, a-f, A-F
    function automatic logic hex_valid(input logic [7:0] b);
        hex_valid = (b >= 8'h30 && b <= 8'h39) ||
                    (b >= 8'h61 && b <= 8'h66) ||
                    (b >= 8'h41 && b <= 8'h46);
    endfunction

    // nibble value of a hex digit, zero for anything else
    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = b - 8'h30;
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            v = b - 8'h61 + 8'd10;
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            v = b - 8'h41 + 8'd10;
        end
        hex_value = v[3:0];
    endfunction

endpackage

@@ src/pdec_front.sv @@
// front end: tracks the escape phase and turns each input item into a queue entry
module pdec_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output logic                 push,
    output pdec_pkg::pdec_entry_t entry,
    output logic                 idle
);

    pdec_pkg::pdec_phase_t phase_reg, phase_next;
    logic [7:0]            held_reg, held_next;

    // classify the byte and build the list of bytes to emit
    always_comb
    begin
        logic       is_hex;
        logic       is_pct;
        logic [1:0] cnt;
        is_hex     = pdec_pkg::hex_valid(in_byte);
        is_pct     = (in_byte == pdec_pkg::PCT_CHAR);
        cnt        = 2'd0;
        entry      = '0;
        phase_next = phase_reg;
        held_next  = held_reg;

        case (phase_reg)
            pdec_pkg::PH_PCT:
            begin
                if (is_hex)
                begin
                    held_next  = in_byte;
                    phase_next = pdec_pkg::PH_DIGIT;
                end
                else
                begin
                    entry.bytes[cnt] = pdec_pkg::PCT_CHAR;
                    cnt = cnt + 2'd1;
                    if (is_pct)
                    begin
                        phase_next = pdec_pkg::PH_PCT;
                    end
                    else
                    begin
                        entry.bytes[cnt] = in_byte;
                        cnt = cnt + 2'd1;
                        phase_next = pdec_pkg::PH_IDLE;
                    end
                end
            end
            pdec_pkg::PH_DIGIT:
            begin
                if (is_hex)
                begin
                    entry.bytes[cnt] = {pdec_pkg::hex_value(held_reg),
                                        pdec_pkg::hex_value(in_byte)};
                    cnt = cnt + 2'd1;
                    held_next  = 8'h00;
                    phase_next = pdec_pkg::PH_IDLE;
                end
                else
                begin
                    entry.bytes[cnt] = pdec_pkg::PCT_CHAR;
                    cnt = cnt + 2'd1;
                    entry.bytes[cnt] = held_reg;
                    cnt = cnt + 2'd1;
                    held_next = 8'h00;
                    if (is_pct)
                    begin
                        phase_next = pdec_pkg::PH_PCT;
                    end
                    else
                    begin
                        entry.bytes[cnt] = in_byte;
                        cnt = cnt + 2'd1;
                        phase_next = pdec_pkg::PH_IDLE;
                    end
                end
            end
            default:
            begin
                if (is_pct)
                begin
                    phase_next = pdec_pkg::PH_PCT;
                end
                else
                begin
                    entry.bytes[cnt] = in_byte;
                    cnt = cnt + 2'd1;
                    phase_next = pdec_pkg::PH_IDLE;
                end
            end
        endcase

        // end of string flushes whatever escape is pending
        if (in_last)
        begin
            if (phase_next == pdec_pkg::PH_PCT)
            begin
                entry.bytes[cnt] = pdec_pkg::PCT_CHAR;
                cnt = cnt + 2'd1;
            end
            else if (phase_next == pdec_pkg::PH_DIGIT)
            begin
                entry.bytes[cnt] = pdec_pkg::PCT_CHAR;
                cnt = cnt + 2'd1;
                entry.bytes[cnt] = held_next;
                cnt = cnt + 2'd1;
            end
            phase_next = pdec_pkg::PH_IDLE;
            held_next  = 8'h00;
        end

        entry.count = cnt;
        entry.last  = in_last;
    end

    assign push = accept && (entry.count != 2'd0);
    assign idle = (phase_reg == pdec_pkg::PH_IDLE);

    // phase and held digit advance on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pdec_pkg::PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

@@ src/pdec_fifo.sv @@
// short queue of entries between the front end and the back end
module pdec_fifo #(
    parameter int DEPTH = pdec_pkg::FIFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pdec_pkg::pdec_entry_t wr_entry,
    input  logic                  pop,
    output pdec_pkg::pdec_entry_t head,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pdec_pkg::pdec_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/pdec_back.sv @@
// back end: sends the bytes of the head entry one per cycle while the output is not stalled, through an output register
module pdec_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdec_pkg::pdec_entry_t head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // out_byte [7:0]
    output logic                  m_tlast
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       load;
    logic       take;
    logic       final_byte;

    // output register frees up when empty or being taken
    assign load       = !valid_reg || m_tready;
    assign take       = load && !empty;
    assign final_byte = (idx_reg == head.count - 2'd1);
    assign pop        = take && final_byte;

    // byte index within the head entry and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                idx_reg <= final_byte ? 2'd0 : idx_reg + 2'd1;
            end
            if (load)
            begin
                valid_reg <= !empty;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= head.bytes[idx_reg];
            last_reg <= head.last && final_byte;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

@@ src/percent_escape_decoder.sv @@
// top level of the percent-escape decoder: front end, queue, back end
// Decodes a percent-escaped string arriving one byte per item, tlast on the final
// byte; each "%hh" (either case) becomes one byte, a malformed escape passes its
// bytes through literally, and the final output byte carries tlast. An input item
// is taken every cycle while the entry queue (FIFO_DEPTH entries) has room; each
// item yields zero to three bytes, an item that yields any becomes one queue entry,
// and the back end sends one byte per cycle while m_tready holds, so sustained rate
// is one item per cycle as long as the output bytes per item average one or less.
// Items yielding two or three bytes hold the back end while they go out byte by
// byte, and input stalls only once the queue fills. An accepted item is written
// into the queue, and its first byte then passes through the output register.
module percent_escape_decoder #(
    parameter int FIFO_DEPTH = pdec_pkg::FIFO_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte [7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte [7:0]
    output logic       m_tlast
);

    logic                  accept;
    logic                  push;
    logic                  pop;
    logic                  full;
    logic                  empty;
    logic                  front_idle;
    pdec_pkg::pdec_entry_t wr_entry;
    pdec_pkg::pdec_entry_t head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // classify input bytes
    pdec_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .push    (push),
        .entry   (wr_entry),
        .idle    (front_idle)
    );

    // decoupling queue
    pdec_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    // serialize bytes to the output
    pdec_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a final byte always yields at least one output byte
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |-> push)
        else $error("final item produced no entry");

    // no escape survives the end of a string
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> front_idle)
        else $error("escape pending after end of string");

    // queued entries always hold at least one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> head.count != 2'd0)
        else $error("empty entry in queue");

endmodule
